### hw/rtl/lpc_pkg.sv
package lpc_pkg;

  localparam int unsigned PIXEL_BITS = 16;
  localparam logic [15:0] PIX_TOP    = 16'((32'd1 << PIXEL_BITS) - 32'd1);
  localparam logic [15:0] TOP_CODE   = 16'hFFFE;
  localparam logic [15:0] KNEE_RESET = 16'd40000;

  localparam int unsigned MANT_W   = 32;
  localparam int unsigned E_W      = 5;
  localparam int unsigned LOG_FRAC = 24;
  localparam int unsigned LOG_W    = E_W + LOG_FRAC;
  localparam int unsigned NUM_W    = 46;
  localparam int unsigned DEN_W    = LOG_W + 1;
  localparam int unsigned Q_W      = 17;
  localparam logic [16:0] FULL2    = 17'd131070;

  // Log lanes for the pixel (x) and the knee (k)
  typedef struct packed {
    logic                zero;
    logic                sat;
    logic [E_W-1:0]      ex;
    logic [E_W-1:0]      ek;
    logic [MANT_W-1:0]   mx;
    logic [MANT_W-1:0]   mk;
    logic [LOG_FRAC-1:0] fx;
    logic [LOG_FRAC-1:0] fk;
  } log_beat_t;

  // Long-division state
  typedef struct packed {
    logic             zero;
    logic             sat;
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] ds;
    logic [Q_W-1:0]   q;
  } div_beat_t;

  // One squaring step: {fraction bit, next mantissa}
  function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
    logic [2*MANT_W-1:0] p;
    logic [MANT_W:0]     s;
    p = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
    s = p[2*MANT_W-1:MANT_W-1];
    if (s[MANT_W]) begin
      return {1'b1, s[MANT_W:1]};
    end else begin
      return {1'b0, s[MANT_W-1:0]};
    end
  endfunction

  // Leading-one position of a 17-bit value
  function automatic logic [E_W-1:0] lead_one(input logic [16:0] v);
    logic [E_W-1:0] e;
    e = '0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) e = E_W'(i);
    end
    return e;
  endfunction

  // Mantissa normalized to Q1.31
  function automatic logic [MANT_W-1:0] norm(input logic [16:0] v,
                                             input logic [E_W-1:0] e);
    logic [MANT_W-1:0] w;
    w = {15'd0, v};
    return w << (5'd31 - e);
  endfunction

endpackage

### hw/rtl/lpc_log_stage.sv
module lpc_log_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  lpc_pkg::log_beat_t    beat_i,
  output logic                  valid_o,
  output lpc_pkg::log_beat_t    beat_o
);

  logic                 valid_q;
  lpc_pkg::log_beat_t   beat_d, beat_q;
  logic [lpc_pkg::MANT_W:0] sx, sk;

  // One fraction bit per lane
  always_comb begin
    sx = lpc_pkg::sq_step(beat_i.mx);
    sk = lpc_pkg::sq_step(beat_i.mk);
    beat_d    = beat_i;
    beat_d.mx = sx[lpc_pkg::MANT_W-1:0];
    beat_d.mk = sk[lpc_pkg::MANT_W-1:0];
    beat_d.fx = {beat_i.fx[lpc_pkg::LOG_FRAC-2:0], sx[lpc_pkg::MANT_W]};
    beat_d.fk = {beat_i.fk[lpc_pkg::LOG_FRAC-2:0], sk[lpc_pkg::MANT_W]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

### hw/rtl/lpc_div_stage.sv
module lpc_div_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  lpc_pkg::div_beat_t    beat_i,
  output logic                  valid_o,
  output lpc_pkg::div_beat_t    beat_o
);

  logic               valid_q;
  lpc_pkg::div_beat_t beat_d, beat_q;
  logic               take;

  // Restoring step: one quotient bit
  always_comb begin
    take      = beat_i.rem >= beat_i.ds;
    beat_d    = beat_i;
    beat_d.rem = take ? (beat_i.rem - beat_i.ds) : beat_i.rem;
    beat_d.ds  = beat_i.ds >> 1;
    beat_d.q   = {beat_i.q[lpc_pkg::Q_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

### hw/rtl/log_pixel_compressor.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------
// input    | in_valid_i / in_ready_o    | pixel_in_i [15:0]
// output   | out_valid_o / out_ready_i  | mapped_pixel_o [15:0]
// config   | knee_value_we_i            | knee_value_i [15:0]
//
// One pixel per clock unless the output stalls. Stages: input, 24 squaring
// stages for the log2 fraction, multiply, range check, 17 divide stages, output.
// The squaring stages each hold two 32x32 multipliers (pixel and knee lane).
// Reset clears all valid bits and loads the knee with 40000.
// A stalled output freezes the whole pipeline; no beat is lost or repeated.
module log_pixel_compressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pixel_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] mapped_pixel_o,
  input  logic        knee_value_we_i,
  input  logic [15:0] knee_value_i
);

  localparam int unsigned NLOG = lpc_pkg::LOG_FRAC;
  localparam int unsigned NDIV = lpc_pkg::Q_W;

  logic               en;
  logic [15:0]        knee_q;

  logic               lv [0:NLOG];
  lpc_pkg::log_beat_t lb [0:NLOG];
  logic               dv [0:NDIV];
  lpc_pkg::div_beat_t db [0:NDIV];

  logic               mv_q;
  logic               mzero_q, msat_q;
  logic [lpc_pkg::NUM_W-1:0] num_q;
  logic [lpc_pkg::DEN_W-1:0] den_q;

  logic               ov_q;
  logic [15:0]        res_q, res_d;

  // Whole pipeline advances unless the output beat is stuck
  assign en         = !ov_q || out_ready_i;
  assign in_ready_o = en;

  // Knee register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knee_q <= lpc_pkg::KNEE_RESET;
    end else if (knee_value_we_i) begin
      knee_q <= knee_value_i;
    end
  end

  // Input stage: special cases and normalization
  logic [16:0]              vx, vk;
  logic [lpc_pkg::E_W-1:0]  ex, ek;
  lpc_pkg::log_beat_t       in_d;
  logic                     in_v_q;
  lpc_pkg::log_beat_t       in_q;

  always_comb begin
    vx = {1'b0, pixel_in_i} + 17'd1;
    vk = {1'b0, knee_q} + 17'd1;
    ex = lpc_pkg::lead_one(vx);
    ek = lpc_pkg::lead_one(vk);
    in_d.zero = pixel_in_i == 16'd0;
    in_d.sat  = (pixel_in_i >= lpc_pkg::PIX_TOP) || (knee_q == 16'd0);
    in_d.ex   = ex;
    in_d.ek   = ek;
    in_d.mx   = lpc_pkg::norm(vx, ex);
    in_d.mk   = lpc_pkg::norm(vk, ek);
    in_d.fx   = '0;
    in_d.fk   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_d;
    end
  end

  assign lv[0] = in_v_q;
  assign lb[0] = in_q;

  // Squaring chain
  for (genvar g = 0; g < NLOG; g++) begin : g_log
    lpc_log_stage u_log (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (lv[g]),
      .beat_i  (lb[g]),
      .valid_o (lv[g+1]),
      .beat_o  (lb[g+1])
    );
  end

  // Numerator 2*65535*lx + lk, denominator 2*lk
  logic [lpc_pkg::LOG_W-1:0] lx, lk;
  assign lx = {lb[NLOG].ex, lb[NLOG].fx};
  assign lk = {lb[NLOG].ek, lb[NLOG].fk};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en) begin
      mv_q <= lv[NLOG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mzero_q <= lb[NLOG].zero;
      msat_q  <= lb[NLOG].sat;
      num_q   <= lpc_pkg::NUM_W'(lx) * lpc_pkg::NUM_W'(lpc_pkg::FULL2)
                 + lpc_pkg::NUM_W'(lk);
      den_q   <= {lk, 1'b0};
    end
  end

  // Range check: quotient of 2^17 or more saturates
  logic               rv_q;
  lpc_pkg::div_beat_t r_q, r_d;
  logic [lpc_pkg::NUM_W:0] lim;

  always_comb begin
    lim      = (lpc_pkg::NUM_W+1)'(den_q) << lpc_pkg::Q_W;
    r_d.zero = mzero_q;
    r_d.sat  = msat_q || ({1'b0, num_q} >= lim);
    r_d.rem  = num_q;
    r_d.ds   = lpc_pkg::NUM_W'(den_q) << (lpc_pkg::Q_W - 1);
    r_d.q    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q <= r_d;
    end
  end

  assign dv[0] = rv_q;
  assign db[0] = r_q;

  // Divider chain
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    lpc_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[g]),
      .beat_i  (db[g]),
      .valid_o (dv[g+1]),
      .beat_o  (db[g+1])
    );
  end

  // Output stage: zero pixel first, then clamp
  always_comb begin
    if (db[NDIV].zero) begin
      res_d = 16'd0;
    end else if (db[NDIV].sat || (db[NDIV].q > lpc_pkg::Q_W'(lpc_pkg::TOP_CODE))) begin
      res_d = lpc_pkg::TOP_CODE;
    end else begin
      res_d = db[NDIV].q[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign mapped_pixel_o = res_q;

  // Checks
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mapped_pixel_o))
    else $error("output beat changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mapped_pixel_o <= lpc_pkg::TOP_CODE)
    else $error("result above clamp");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline stalled with empty output");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(rv_q) && $stable(mv_q))
    else $error("stage moved during stall");

endmodule
